// ----- rtl/jss_pkg.sv -----
// shared types and constants of the jog scratch speed controller
`default_nettype none
package jss_pkg;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] CFG_ENABLED     = 2'd0;
  localparam logic [1:0] CFG_SENSITIVITY = 2'd1;
  localparam logic [1:0] CFG_INERTIA     = 2'd2;

  localparam logic [13:0] DT_MIN      = 14'd66;
  localparam logic [13:0] DT_MAX      = 14'd13107;
  localparam logic [9:0]  SENS_MIN    = 10'd51;
  localparam logic [9:0]  SENS_MAX    = 10'd768;
  localparam logic [15:0] INERTIA_MIN = 16'd49152;
  localparam logic [15:0] INERTIA_MAX = 16'd64881;
  localparam logic [14:0] SPEED_ONE   = 15'd4096;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pos;
    logic [13:0] dt;
  } jss_item_t;

endpackage
`default_nettype wire

// ----- rtl/jss_front.sv -----
// front end: accepts beats, clamps the time step and queues them
`default_nettype none
module jss_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [15:0]      position_x_i,
  input  wire logic [15:0]      delta_time_i,
  output logic                  q_valid_o,
  output jss_pkg::jss_item_t    q_item_o,
  input  wire logic             q_pop_i
);

  jss_pkg::jss_item_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic [13:0] dt_c;
  logic push, pop;

  always_comb begin
    if (delta_time_i < {2'b0, jss_pkg::DT_MIN}) begin
      dt_c = jss_pkg::DT_MIN;
    end else if (delta_time_i > {2'b0, jss_pkg::DT_MAX}) begin
      dt_c = jss_pkg::DT_MAX;
    end else begin
      dt_c = delta_time_i[13:0];
    end
  end

  assign in_stall_o = (count_q == 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rptr_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{op: op_i, pos: position_x_i, dt: dt_c};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jss_back.sv -----
// back end: gesture state, divider, square root chain and result register
`default_nettype none
module jss_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               q_valid_i,
  input  wire jss_pkg::jss_item_t q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    speed_write_o,
  output logic [14:0]             speed_ratio_o,
  output logic                    nudge_write_o,
  output logic signed [19:0]      nudge_amount_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_VMUL, S_VSUM, S_SMUL, S_SFIN,
    S_DWHOLE, S_DSQRT, S_DMUL, S_DMAG, S_DRND, S_TICK
  } state_e;

  state_e state_q;
  logic        en_q, active_q, grip_q, snap_q, neg_q;
  logic [9:0]  sens_q;
  logic [15:0] inertia_q, last_q;
  logic signed [31:0] vel_q;
  logic [14:0] speed_q;
  logic signed [19:0] nudge_q;
  logic signed [16:0] dx_q;
  logic [42:0] num_q, quo_q;
  logic [21:0] den_q, rem_q;
  logic [5:0]  cnt_q;
  logic signed [47:0] p1_q, ps_q;
  logic signed [43:0] p2_q;
  logic [19:0] frames_q;
  logic [3:0]  wcnt_q, bit_q;
  logic [32:0] acc_q;
  logic [31:0] s_q, sroot_q;
  logic [63:0] sn_q;
  logic [32:0] srem_q;
  logic [64:0] magp_q;

  // combinational helpers
  logic signed [16:0] dx_c;
  logic [15:0] dxmag_c;
  logic [25:0] dxsens_c;
  logic [19:0] frames_c;
  logic [22:0] rem_sh;
  logic        div_ge;
  logic [22:0] rem_nx;
  logic signed [29:0] inst_c;
  logic [34:0] srem_sh, strial;
  logic        sq_ge;
  logic [34:0] srem_nx;
  logic [31:0] sroot_nx;
  logic [31:0] mop;
  logic [64:0] mprod;
  logic [32:0] mq;
  logic signed [49:0] vsum;
  logic [49:0] vmag;
  logic [49:0] vr;
  logic signed [49:0] vrs;
  logic signed [31:0] vclamp;
  logic [47:0] psmag;
  logic [47:0] psr;
  logic signed [48:0] spd;
  logic [14:0] sp_lo, sp_hi, sp_c;
  logic signed [29:0] nd;
  logic [29:0] ndmag, ndr;
  logic signed [21:0] nsum;
  logic signed [19:0] nclamp;
  logic [31:0] vabs;
  logic [32:0] mr;
  logic [9:0]  sens_w;
  logic [15:0] inertia_w;

  assign dx_c     = $signed({1'b0, q_item_i.pos}) - $signed({1'b0, last_q});
  assign dxmag_c  = dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
  assign dxsens_c = {10'b0, dxmag_c} * {16'b0, sens_q};
  assign frames_c = {6'b0, q_item_i.dt} * 20'd60;

  assign rem_sh = {rem_q, num_q[42]};
  assign div_ge = rem_sh >= {1'b0, den_q};
  assign rem_nx = div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign inst_c = neg_q ? -$signed({1'b0, quo_q[28:0]}) : $signed({1'b0, quo_q[28:0]});

  assign srem_sh  = {srem_q, sn_q[63:62]};
  assign strial   = {1'b0, sroot_q, 2'b01};
  assign sq_ge    = srem_sh >= strial;
  assign srem_nx  = sq_ge ? srem_sh - strial : srem_sh;
  assign sroot_nx = {sroot_q[30:0], sq_ge};

  assign mop   = (state_q == S_DWHOLE) ? {inertia_q, 16'b0} : s_q;
  assign mprod = acc_q * mop;
  assign mq    = 33'((mprod + 65'h80000000) >> 32);

  always_comb begin
    vsum   = 50'(p1_q) + 50'(p2_q);
    vmag   = vsum[49] ? 50'(-vsum) : 50'(vsum);
    vr     = (vmag + 50'd32768) >> 16;
    vrs    = vsum[49] ? -$signed(vr) : $signed(vr);
    if (vrs > 50'sd2147483647) begin
      vclamp = 32'sh7fffffff;
    end else if (vrs < -50'sd2147483648) begin
      vclamp = 32'sh80000000;
    end else begin
      vclamp = vrs[31:0];
    end
  end

  always_comb begin
    psmag = ps_q[47] ? 48'(-ps_q) : 48'(ps_q);
    psr   = (psmag + 48'd524288) >> 20;
    spd   = ps_q[47] ? 49'sd4096 - $signed({1'b0, psr}) : 49'sd4096 + $signed({1'b0, psr});
    sp_lo = grip_q ? 15'd205 : 15'd1024;
    sp_hi = grip_q ? 15'd16384 : 15'd10240;
    if (spd < $signed({34'b0, sp_lo})) begin
      sp_c = sp_lo;
    end else if (spd > $signed({34'b0, sp_hi})) begin
      sp_c = sp_hi;
    end else begin
      sp_c = spd[14:0];
    end
  end

  always_comb begin
    nd    = 30'(dx_q) * $signed({18'b0, sens_q, 2'b0} - {20'b0, sens_q});
    ndmag = nd[29] ? 30'(-nd) : 30'(nd);
    ndr   = (ndmag + 30'd512) >> 10;
    nsum  = nd[29] ? 22'(nudge_q) - $signed({2'b0, ndr[19:0]})
                   : 22'(nudge_q) + $signed({2'b0, ndr[19:0]});
    if (nsum > 22'sd524287) begin
      nclamp = 20'sh7ffff;
    end else if (nsum < -22'sd524288) begin
      nclamp = 20'sh80000;
    end else begin
      nclamp = nsum[19:0];
    end
  end

  assign vabs = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
  assign mr   = 33'((magp_q + 65'h80000000) >> 32);

  always_comb begin
    if (cfg_data_i[9:0] < jss_pkg::SENS_MIN) begin
      sens_w = jss_pkg::SENS_MIN;
    end else if (cfg_data_i[9:0] > jss_pkg::SENS_MAX) begin
      sens_w = jss_pkg::SENS_MAX;
    end else begin
      sens_w = cfg_data_i[9:0];
    end
    if (cfg_data_i < jss_pkg::INERTIA_MIN) begin
      inertia_w = jss_pkg::INERTIA_MIN;
    end else if (cfg_data_i > jss_pkg::INERTIA_MAX) begin
      inertia_w = jss_pkg::INERTIA_MAX;
    end else begin
      inertia_w = cfg_data_i;
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && !out_valid_o && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      en_q           <= 1'b0;
      sens_q         <= 10'd256;
      inertia_q      <= 16'd62259;
      active_q       <= 1'b0;
      last_q         <= 16'd0;
      vel_q          <= 32'sd0;
      speed_q        <= jss_pkg::SPEED_ONE;
      nudge_q        <= 20'sd0;
      out_valid_o    <= 1'b0;
      speed_write_o  <= 1'b0;
      speed_ratio_o  <= 15'd0;
      nudge_write_o  <= 1'b0;
      nudge_amount_o <= 20'sd0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          jss_pkg::CFG_ENABLED: begin
            en_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              active_q <= 1'b0;
              vel_q    <= 32'sd0;
              speed_q  <= jss_pkg::SPEED_ONE;
              nudge_q  <= 20'sd0;
            end
          end
          jss_pkg::CFG_SENSITIVITY: sens_q <= sens_w;
          jss_pkg::CFG_INERTIA:     inertia_q <= inertia_w;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            out_valid_o    <= 1'b1;
            speed_write_o  <= 1'b0;
            speed_ratio_o  <= 15'd0;
            nudge_write_o  <= 1'b0;
            nudge_amount_o <= 20'sd0;
            case (q_item_i.op)
              jss_pkg::OP_BEGIN: begin
                if (en_q) begin
                  active_q <= 1'b1;
                  last_q   <= q_item_i.pos;
                  vel_q    <= 32'sd0;
                  speed_q  <= jss_pkg::SPEED_ONE;
                  nudge_q  <= 20'sd0;
                end
              end
              jss_pkg::OP_UPDATE: begin
                if (en_q && active_q) begin
                  out_valid_o <= 1'b0;
                  dx_q   <= dx_c;
                  neg_q  <= dx_c[16];
                  num_q  <= {1'b0, dxsens_c, 16'b0} + {22'b0, q_item_i.dt, 7'b0};
                  den_q  <= {q_item_i.dt, 8'b0};
                  rem_q  <= 22'd0;
                  quo_q  <= 43'd0;
                  cnt_q  <= 6'd0;
                  last_q <= q_item_i.pos;
                  grip_q <= 1'b1;
                  snap_q <= 1'b0;
                  state_q <= S_DIV;
                end
              end
              jss_pkg::OP_END: active_q <= 1'b0;
              default: begin
                if (en_q) begin
                  out_valid_o <= 1'b0;
                  if (!active_q) begin
                    frames_q <= frames_c;
                    wcnt_q   <= frames_c[19:16];
                    acc_q    <= 33'h100000000;
                    s_q      <= {inertia_q, 16'b0};
                    state_q  <= S_DWHOLE;
                  end else begin
                    state_q <= S_TICK;
                  end
                end
              end
            endcase
          end
        end
        S_DIV: begin
          rem_q <= rem_nx[21:0];
          num_q <= {num_q[41:0], 1'b0};
          quo_q <= {quo_q[41:0], div_ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd42) state_q <= S_VMUL;
        end
        S_VMUL: begin
          p1_q <= 48'(vel_q) * 48'sd53740;
          p2_q <= 44'(inst_c) * 44'sd11796;
          state_q <= S_VSUM;
        end
        S_VSUM: begin
          vel_q   <= vclamp;
          state_q <= S_SMUL;
        end
        S_SMUL: begin
          ps_q    <= 48'(vel_q) * 48'sd22938;
          state_q <= S_SFIN;
        end
        S_SFIN: begin
          if (snap_q) begin
            vel_q   <= 32'sd0;
            speed_q <= jss_pkg::SPEED_ONE;
          end else begin
            speed_q <= sp_c;
          end
          if (grip_q) begin
            nudge_q        <= nclamp;
            out_valid_o    <= 1'b1;
            speed_write_o  <= 1'b0;
            speed_ratio_o  <= 15'd0;
            nudge_write_o  <= 1'b0;
            nudge_amount_o <= 20'sd0;
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_TICK;
          end
        end
        S_DWHOLE: begin
          if (wcnt_q != 4'd0) begin
            acc_q  <= mq;
            wcnt_q <= wcnt_q - 4'd1;
          end else begin
            sn_q    <= {s_q, 32'b0};
            srem_q  <= 33'd0;
            sroot_q <= 32'd0;
            cnt_q   <= 6'd0;
            bit_q   <= 4'd15;
            state_q <= S_DSQRT;
          end
        end
        S_DSQRT: begin
          sn_q    <= {sn_q[61:0], 2'b00};
          srem_q  <= srem_nx[32:0];
          sroot_q <= sroot_nx;
          cnt_q   <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            s_q <= sroot_nx;
            if (frames_q[bit_q]) begin
              state_q <= S_DMUL;
            end else if (bit_q == 4'd0) begin
              state_q <= S_DMAG;
            end else begin
              bit_q   <= bit_q - 4'd1;
              sn_q    <= {sroot_nx, 32'b0};
              srem_q  <= 33'd0;
              sroot_q <= 32'd0;
              cnt_q   <= 6'd0;
            end
          end
        end
        S_DMUL: begin
          acc_q <= mq;
          if (bit_q == 4'd0) begin
            state_q <= S_DMAG;
          end else begin
            bit_q   <= bit_q - 4'd1;
            sn_q    <= {s_q, 32'b0};
            srem_q  <= 33'd0;
            sroot_q <= 32'd0;
            cnt_q   <= 6'd0;
            state_q <= S_DSQRT;
          end
        end
        S_DMAG: begin
          magp_q  <= 65'(vabs) * 65'(acc_q);
          state_q <= S_DRND;
        end
        S_DRND: begin
          vel_q   <= vel_q[31] ? -$signed(mr[31:0]) : $signed(mr[31:0]);
          snap_q  <= mr <= 33'd32;
          grip_q  <= 1'b0;
          state_q <= S_SMUL;
        end
        S_TICK: begin
          out_valid_o    <= 1'b1;
          speed_write_o  <= 1'b1;
          speed_ratio_o  <= speed_q;
          nudge_write_o  <= nudge_q != 20'sd0;
          nudge_amount_o <= nudge_q;
          nudge_q        <= 20'sd0;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jog_scratch_speed_controller_top.sv -----
// top level of the jog scratch speed controller
`default_nettype none
// A two-entry input queue takes beats while the back end works; results leave
// through an output register. An update runs the 43-step restoring divider for
// the drag velocity. A tick while released runs the whole-frame multiplies (up
// to 11) and the chain of sixteen 32-step square roots of the inertia factor.
// Configuration writes are registered.
module jog_scratch_speed_controller_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [15:0]        position_x_i,
  input  wire logic [15:0]        delta_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    speed_write_o,
  output logic [14:0]             speed_ratio_o,
  output logic                    nudge_write_o,
  output logic signed [19:0]      nudge_amount_o
);

  logic               q_valid, q_pop;
  jss_pkg::jss_item_t q_item;

  jss_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .position_x_i,
    .delta_time_i, .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  jss_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .speed_write_o, .speed_ratio_o,
    .nudge_write_o, .nudge_amount_o
  );

  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !speed_write_o |-> speed_ratio_o == 15'd0)
    else $error("speed ratio set without speed write");

  a_nudge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !nudge_write_o |-> nudge_amount_o == 20'sd0)
    else $error("nudge amount set without nudge write");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speed_write_o |-> speed_ratio_o >= 15'd205 && speed_ratio_o <= 15'd16384)
    else $error("speed ratio out of range");

endmodule
`default_nettype wire

// ----- bench/jss_checker.sv -----
// checker: predicts the speed controller results and compares the output beats
module jss_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [1:0]         op_i,
  input  wire logic [15:0]        position_x_i,
  input  wire logic [15:0]        delta_time_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               speed_write_i,
  input  wire logic [14:0]        speed_ratio_i,
  input  wire logic               nudge_write_i,
  input  wire logic signed [19:0] nudge_amount_i,
  output int                      pending_o,
  output int                      fail_count_o
);

  typedef struct packed {
    logic        sw;
    logic [14:0] sr;
    logic        nw;
    logic [19:0] na;
  } speed_beat_t;

  speed_beat_t expected_q[$];

  logic    en;
  longint  sens;
  longint  iner;
  logic    gripped;
  longint  last_pos;
  longint  vel;
  longint  spd;
  longint  nudge;

  assign pending_o = expected_q.size();

  function automatic longint round_div(longint num, longint den);
    if (num < 0) return -((-num + den / 2) / den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 31)) >> 32;
  endfunction

  function automatic longint unsigned decay_factor(longint unsigned dt);
    longint unsigned frames;
    longint unsigned base;
    longint unsigned acc;
    longint unsigned s;
    frames = dt * 60;
    base = longint'(iner) << 16;
    acc = 64'd1 << 32;
    s = base;
    for (longint unsigned k = 0; k < (frames >> 16); k++) acc = mul_frac(acc, base);
    for (int i = 15; i >= 0; i--) begin
      s = floor_sqrt(s << 32);
      if (frames[i]) acc = mul_frac(acc, s);
    end
    return acc;
  endfunction

  function automatic longint speed_for(longint v, longint lo, longint hi);
    return clip(4096 + round_div(v * 22938, 64'd1 << 20), lo, hi);
  endfunction

  function automatic void drop_gesture();
    gripped = 1'b0;
    vel = 0;
    spd = 4096;
    nudge = 0;
  endfunction

  function automatic speed_beat_t predict(logic [1:0] op, logic [15:0] pos, logic [15:0] dt_raw);
    speed_beat_t r;
    longint dt;
    longint dx;
    longint inst;
    longint unsigned mag;
    logic neg;
    r = '0;
    dt = clip(longint'(dt_raw), longint'(jss_pkg::DT_MIN), longint'(jss_pkg::DT_MAX));
    case (op)
      jss_pkg::OP_BEGIN: begin
        if (en) begin
          drop_gesture();
          gripped = 1'b1;
          last_pos = longint'(pos);
        end
      end
      jss_pkg::OP_UPDATE: begin
        if (en && gripped) begin
          dx = longint'(pos) - last_pos;
          inst = round_div(dx * 65536 * sens, dt * 256);
          last_pos = longint'(pos);
          vel = clip(round_div(53740 * vel + 11796 * inst, 65536), -64'sd2147483648,
                     64'sd2147483647);
          spd = speed_for(vel, 205, 16384);
          nudge = clip(nudge + round_div(dx * sens * 3, 1024), -524288, 524287);
        end
      end
      jss_pkg::OP_END: gripped = 1'b0;
      default: begin
        if (en) begin
          if (!gripped) begin
            neg = vel < 0;
            mag = neg ? -vel : vel;
            mag = (mag * decay_factor(dt) + (64'd1 << 31)) >> 32;
            vel = neg ? -longint'(mag) : longint'(mag);
            spd = speed_for(vel, 1024, 10240);
            if (mag <= 32) begin
              vel = 0;
              spd = 4096;
            end
          end
          r.sw = 1'b1;
          r.sr = spd[14:0];
          if (nudge != 0) begin
            r.nw = 1'b1;
            r.na = nudge[19:0];
            nudge = 0;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    speed_beat_t e;
    if (!rst_ni) begin
      en = 1'b0;
      sens = 256;
      iner = 62259;
      last_pos = 0;
      drop_gesture();
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          jss_pkg::CFG_ENABLED: begin
            en = cfg_data_i[0];
            if (!en) drop_gesture();
          end
          jss_pkg::CFG_SENSITIVITY: sens = clip(longint'(cfg_data_i[9:0]),
                                                longint'(jss_pkg::SENS_MIN),
                                                longint'(jss_pkg::SENS_MAX));
          jss_pkg::CFG_INERTIA: iner = clip(longint'(cfg_data_i),
                                            longint'(jss_pkg::INERTIA_MIN),
                                            longint'(jss_pkg::INERTIA_MAX));
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("output beat with nothing expected");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (speed_write_i !== e.sw) begin
            $error("speed_write expected %0d got %0d", e.sw, speed_write_i);
            fail_count_o++;
          end
          if (speed_ratio_i !== e.sr) begin
            $error("speed_ratio expected %0d got %0d", e.sr, speed_ratio_i);
            fail_count_o++;
          end
          if (nudge_write_i !== e.nw) begin
            $error("nudge_write expected %0d got %0d", e.nw, nudge_write_i);
            fail_count_o++;
          end
          if (nudge_amount_i !== $signed(e.na)) begin
            $error("nudge_amount expected %0d got %0d", $signed(e.na), nudge_amount_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict(op_i, position_x_i, delta_time_i));
    end
  end

endmodule

// ----- bench/tb_jog_scratch_speed_controller_top.sv -----
// testbench top: stimulus, idling and verdict for the jog scratch speed controller
module tb_jog_scratch_speed_controller_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = '0;
  logic [15:0]        position_x = '0;
  logic [15:0]        delta_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               speed_write;
  logic [14:0]        speed_ratio;
  logic               nudge_write;
  logic signed [19:0] nudge_amount;
  int                 pending;
  int                 fail_count;
  int                 burst_left = 0;
  int                 sent = 0;
  logic [15:0]        drag_pos = '0;

  jog_scratch_speed_controller_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .position_x_i(position_x), .delta_time_i(delta_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .speed_write_o(speed_write), .speed_ratio_o(speed_ratio),
    .nudge_write_o(nudge_write), .nudge_amount_o(nudge_amount)
  );

  jss_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .position_x_i(position_x), .delta_time_i(delta_time),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .speed_write_i(speed_write), .speed_ratio_i(speed_ratio),
    .nudge_write_i(nudge_write), .nudge_amount_i(nudge_amount),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall pattern with a randomly chosen mode
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_cnt % 16) < 11;
    endcase
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send(logic [1:0] o, logic [15:0] p, logic [15:0] d);
    int gap;
    in_valid <= 1'b1;
    op <= o;
    position_x <= p;
    delta_time <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 200));
      default: return 16'($urandom_range(66, 3000));
    endcase
  endfunction

  task automatic random_phase(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        drag_pos = rand16();
        send(jss_pkg::OP_BEGIN, drag_pos, rand16());
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 7) == 0) drag_pos = rand16();
          else drag_pos = drag_pos + 16'($urandom_range(0, 4000)) - 16'd2000;
          if ($urandom_range(0, 5) == 0) send(jss_pkg::OP_TICK, rand16(), rand_dt());
          send(jss_pkg::OP_UPDATE, drag_pos, rand_dt());
        end
        send(jss_pkg::OP_TICK, rand16(), rand_dt());
        send(jss_pkg::OP_END, rand16(), rand16());
        repeat ($urandom_range(1, 10)) send(jss_pkg::OP_TICK, rand16(), rand_dt());
      end else begin
        send(2'($urandom_range(0, 3)), rand16(), rand_dt());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // disabled block
    send(jss_pkg::OP_BEGIN, 16'd100, 16'd0);
    send(jss_pkg::OP_UPDATE, 16'd9000, 16'd1000);
    send(jss_pkg::OP_TICK, 16'd0, 16'd1000);
    send(jss_pkg::OP_END, 16'd0, 16'd0);
    write_reg(jss_pkg::CFG_ENABLED, 16'd1);
    send(jss_pkg::OP_UPDATE, 16'd500, 16'd500);
    send(jss_pkg::OP_BEGIN, 16'd0, 16'd0);
    send(jss_pkg::OP_UPDATE, 16'hFFFF, 16'd0);
    send(jss_pkg::OP_TICK, 16'd0, 16'd0);
    send(jss_pkg::OP_UPDATE, 16'd0, 16'hFFFF);
    send(jss_pkg::OP_UPDATE, 16'hFFFF, 16'd66);
    send(jss_pkg::OP_TICK, 16'hFFFF, 16'd13107);
    send(jss_pkg::OP_END, 16'hFFFF, 16'hFFFF);
    send(jss_pkg::OP_TICK, 16'd0, 16'hFFFF);
    send(jss_pkg::OP_TICK, 16'd0, 16'd0);
    repeat (6) send(jss_pkg::OP_TICK, 16'd0, 16'd13107);
    send(jss_pkg::OP_TICK, 16'd0, 16'd5000);
    write_reg(jss_pkg::CFG_SENSITIVITY, 16'hFFFF);
    write_reg(jss_pkg::CFG_INERTIA, 16'hFFFF);
    send(jss_pkg::OP_BEGIN, 16'd0, 16'd0);
    send(jss_pkg::OP_UPDATE, 16'hFFFF, 16'd0);
    send(jss_pkg::OP_END, 16'd0, 16'd0);
    send(jss_pkg::OP_TICK, 16'd0, 16'd66);
    random_phase(250);
    write_reg(jss_pkg::CFG_SENSITIVITY, 16'd0);
    write_reg(jss_pkg::CFG_INERTIA, 16'd0);
    random_phase(250);
    write_reg(jss_pkg::CFG_SENSITIVITY, rand16());
    write_reg(jss_pkg::CFG_INERTIA, rand16());
    random_phase(250);
    write_reg(jss_pkg::CFG_ENABLED, 16'hFFFE);
    random_phase(60);
    write_reg(jss_pkg::CFG_ENABLED, 16'hFFFF);
    write_reg(jss_pkg::CFG_SENSITIVITY, 16'd768);
    write_reg(jss_pkg::CFG_INERTIA, 16'd49152);
    random_phase(250);
    write_reg(jss_pkg::CFG_SENSITIVITY, 16'($urandom_range(51, 768)));
    write_reg(jss_pkg::CFG_INERTIA, 16'($urandom_range(49152, 64881)));
    random_phase(150);
    // disable in the middle of a gesture with a pending nudge
    send(jss_pkg::OP_BEGIN, 16'd1000, 16'd0);
    send(jss_pkg::OP_UPDATE, 16'd3000, 16'd700);
    write_reg(jss_pkg::CFG_ENABLED, 16'd0);
    write_reg(jss_pkg::CFG_ENABLED, 16'd1);
    send(jss_pkg::OP_TICK, 16'd0, 16'd700);
    random_phase(150);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/jss_pkg.sv
rtl/jss_front.sv
rtl/jss_back.sv
rtl/jog_scratch_speed_controller_top.sv
bench/jss_checker.sv
bench/tb_jog_scratch_speed_controller_top.sv
